### design/rpc_pkg.sv
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, register indexes, pipeline stage map and arithmetic helpers
// for the radiometric pixel calibration core.
// ----------------------------------------------------------------------------
package rpc_pkg;

   typedef logic [15:0]        word16_type;
   typedef logic signed [15:0] pix_type;

   // Operating modes.
   localparam logic [1:0] MODE_REFL  = 2'd0;
   localparam logic [1:0] MODE_THERM = 2'd1;
   localparam logic [1:0] MODE_REMAP = 2'd2;

   // Register indexes.
   localparam logic [2:0] REG_MODE    = 3'd0;
   localparam logic [2:0] REG_IN_FILL = 3'd1;
   localparam logic [2:0] REG_QA_FILL = 3'd2;
   localparam logic [2:0] REG_GAIN    = 3'd3;
   localparam logic [2:0] REG_BIAS    = 3'd4;
   localparam logic [2:0] REG_SCALE   = 3'd5;
   localparam logic [2:0] REG_K1      = 3'd6;
   localparam logic [2:0] REG_K2      = 3'd7;

   // Arithmetic constants.
   localparam logic [31:0]        LN2_Q32      = 32'hB17217F8;
   localparam logic signed [64:0] ZERO_C_Q16   = 65'sd1790115840;
   localparam pix_type            ABS_ZERO_C   = -16'sd27315;
   localparam pix_type            POS_LIMIT    = 16'sd32767;

   // Pipeline stage map.
   localparam int S_SEL  = 4;
   localparam int S_NORM = 5;
   localparam int NUM_SQ = 24;
   localparam int S_LG   = S_NORM + NUM_SQ + 1;
   localparam int S_LN   = S_LG + 1;
   localparam int S_DIV0 = S_LN + 1;
   localparam int Q_BITS = 63;
   localparam int S_OUT  = S_DIV0 + Q_BITS + 1;

   typedef struct packed {
      logic    fill;
      logic    hold;
      pix_type res;
   } carry_type;

   function automatic pix_type sat16(input logic signed [64:0] v);
      pix_type r;
      if (v > 65'sd32767) begin
         r = 16'sd32767;
      end else if (v < -65'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [5:0] msb_index(input logic [49:0] u);
      logic [5:0] e;
      e = '0;
      for (int i = 0; i < 50; i++) begin
         if (u[i]) begin
            e = 6'(i);
         end
      end
      return e;
   endfunction

   // Cuts a Q1.30 mantissa from u, with its top bit at index e.
   function automatic logic [30:0] normalize(input logic [49:0] u, input logic [5:0] e);
      logic [49:0] sh;
      if (e > 6'd30) begin
         sh = u >> (e - 6'd30);
      end else begin
         sh = u << (6'd30 - e);
      end
      return sh[30:0];
   endfunction

   // One squaring step: top bit is the new fraction bit, the rest the mantissa.
   function automatic logic [31:0] square_step(input logic [30:0] x);
      logic [61:0] p;
      logic [31:0] s;
      p = 62'(x) * 62'(x);
      s = p[61:30];
      if (s[31]) begin
         return {1'b1, s[31:1]};
      end
      return {1'b0, s[30:0]};
   endfunction

endpackage

### design/rpc_req_if.sv
// ----------------------------------------------------------------------------
// rpc_req_if
// Request channel: one pixel digital number and its QA word.
// ----------------------------------------------------------------------------
interface rpc_req_if;
   import rpc_pkg::*;

   logic       valid;
   logic       ready;
   word16_type pixel_dn;
   word16_type qa_value;

   modport source (output valid, output pixel_dn, output qa_value, input ready);
   modport sink   (input valid, input pixel_dn, input qa_value, output ready);
endinterface

### design/rpc_rsp_if.sv
// ----------------------------------------------------------------------------
// rpc_rsp_if
// Result channel: one calibrated pixel value and its fill flag.
// ----------------------------------------------------------------------------
interface rpc_rsp_if;
   import rpc_pkg::*;

   logic    valid;
   logic    ready;
   pix_type pixel_out;
   logic    is_fill;

   modport source (output valid, output pixel_out, output is_fill, input ready);
   modport sink   (input valid, input pixel_out, input is_fill, output ready);
endinterface

### design/radiometric_pixel_calibration_core.sv
// ----------------------------------------------------------------------------
// radiometric_pixel_calibration_core
// Per-pixel calibration to reflectance, brightness temperature or DN remap.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle; the whole pipeline advances together
// and holds only while a finished result waits at the output register.
// The depth is set by the 24 squaring stages of the logarithm and the
// 63 one-bit stages of the temperature divider.
// Synchronous reset empties the pipeline and restores the register defaults.
module radiometric_pixel_calibration_core #(
   parameter logic signed [15:0] PIXEL_FILL = -16'sd9999
) (
   input  logic         clock,
   input  logic         reset,
   rpc_req_if.sink      req_channel,
   rpc_rsp_if.source    rsp_channel,
   input  logic         csr_write_en,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_write_data
);
   import rpc_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers. Software must write them only while idle; the
   // block does not enforce this, and every stage reads them directly.
   // ------------------------------------------------------------------
   logic [1:0]         mode_ff;
   logic [15:0]        in_fill_ff;
   logic [15:0]        qa_fill_ff;
   logic signed [31:0] gain_ff;
   logic signed [31:0] bias_ff;
   logic [31:0]        scale_ff;
   logic [31:0]        k1_ff;
   logic [31:0]        k2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_REFL;
         in_fill_ff <= '0;
         qa_fill_ff <= '0;
         gain_ff    <= 32'sd65536;
         bias_ff    <= '0;
         scale_ff   <= 32'd65536;
         k1_ff      <= 32'd43652874;
         k2_ff      <= 32'd84063887;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MODE:    mode_ff    <= csr_write_data[1:0];
            REG_IN_FILL: in_fill_ff <= csr_write_data[15:0];
            REG_QA_FILL: qa_fill_ff <= csr_write_data[15:0];
            REG_GAIN:    gain_ff    <= csr_write_data;
            REG_BIAS:    bias_ff    <= csr_write_data;
            REG_SCALE:   scale_ff   <= csr_write_data;
            REG_K1:      k1_ff      <= csr_write_data;
            REG_K2:      k2_ff      <= csr_write_data;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control. Every stage moves when the output register is empty
   // or its result is being taken.
   // ------------------------------------------------------------------
   logic [S_OUT:1] valid_ff;
   logic [S_OUT:1] valid_in;
   logic           adv;

   assign adv               = !valid_ff[S_OUT] || rsp_channel.ready;
   assign req_channel.ready = adv;

   always_comb begin
      valid_in    = {valid_ff[S_OUT-1:1], req_channel.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: gain times DN. Stage 2: add bias to form the radiance.
   // ------------------------------------------------------------------
   logic signed [48:0] prod1_ff, prod1_in;
   logic signed [48:0] rad2_ff, rad2_in;

   always_comb begin
      prod1_in = gain_ff * $signed({1'b0, req_channel.pixel_dn});
      rad2_in  = prod1_ff + 49'(bias_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod1_ff <= prod1_in;
         rad2_ff  <= rad2_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: reflectance partial products, remap rounding, and the two
   // logarithm arguments for the thermal path.
   // ------------------------------------------------------------------
   logic signed [48:0] nrad;
   logic [47:0]        mag;
   logic [63:0]        plo_full;
   logic signed [48:0] rnd0;
   logic [47:0]        phi3_ff, phi3_in;
   logic [31:0]        plo3_ff, plo3_in;
   logic               neg3_ff, neg3_in;
   logic signed [48:0] rnd3_ff, rnd3_in;
   logic [49:0]        uhi3_ff, uhi3_in;
   logic [49:0]        ulo3_ff, ulo3_in;
   logic               pos3_ff, pos3_in;

   always_comb begin
      nrad     = -rad2_ff;
      mag      = rad2_ff[48] ? nrad[47:0] : rad2_ff[47:0];
      phi3_in  = 48'(mag[47:32]) * 48'(scale_ff);
      plo_full = 64'(mag[31:0]) * 64'(scale_ff);
      plo3_in  = plo_full[63:32];
      neg3_in  = rad2_ff[48];
      // Rounded remap: add one half, then truncate toward zero.
      rnd0     = rad2_ff + 49'sd32768;
      rnd3_in  = rnd0[48] ? rnd0 + 49'sd65535 : rnd0;
      uhi3_in  = 50'(rad2_ff[47:0]) + 50'(k1_ff);
      ulo3_in  = 50'(rad2_ff[47:0]);
      pos3_in  = !rad2_ff[48] && (rad2_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         phi3_ff <= phi3_in;
         plo3_ff <= plo3_in;
         neg3_ff <= neg3_in;
         rnd3_ff <= rnd3_in;
         uhi3_ff <= uhi3_in;
         ulo3_ff <= ulo3_in;
         pos3_ff <= pos3_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: finish reflectance and remap, pick the early result, and
   // find the exponent of each logarithm argument.
   // ------------------------------------------------------------------
   logic [48:0]        q0;
   logic [16:0]        qc;
   logic signed [17:0] s0, sv;
   logic signed [32:0] r2q;
   pix_type            res_refl, res_remap, res_sel;
   logic               hold_sel;
   logic [49:0]        uhi4_ff, ulo4_ff;
   logic [5:0]         eh4_ff, el4_ff;

   always_comb begin
      q0        = 49'(phi3_ff) + 49'(plo3_ff);
      qc        = (q0 > 49'd32768) ? 17'd32768 : q0[16:0];
      s0        = $signed({1'b0, qc});
      sv        = neg3_ff ? -s0 : s0;
      res_refl  = sat16(65'(sv));
      r2q       = $signed(rnd3_ff[48:16]);
      res_remap = sat16(65'(r2q));
      case (mode_ff)
         MODE_THERM: res_sel = ABS_ZERO_C;
         MODE_REMAP: res_sel = res_remap;
         default:    res_sel = res_refl;
      endcase
      // A thermal pixel with positive radiance still needs the log path.
      hold_sel = (mode_ff != MODE_THERM) || !pos3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         uhi4_ff <= uhi3_ff;
         ulo4_ff <= ulo3_ff;
         eh4_ff  <= msb_index(uhi3_ff);
         el4_ff  <= msb_index(ulo3_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 5 and the squaring stages: log2 by repeated squaring of a
   // normalized mantissa, both arguments side by side.
   // ------------------------------------------------------------------
   logic [NUM_SQ:0][30:0]     xh_ff, xl_ff;
   logic [NUM_SQ:0][23:0]     fh_ff, fl_ff;
   logic [NUM_SQ:0][5:0]      eh_ff, el_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         xh_ff[0] <= normalize(uhi4_ff, eh4_ff);
         xl_ff[0] <= normalize(ulo4_ff, el4_ff);
         fh_ff[0] <= '0;
         fl_ff[0] <= '0;
         eh_ff[0] <= eh4_ff;
         el_ff[0] <= el4_ff;
      end
   end

   for (genvar k = 0; k < NUM_SQ; k++) begin : g_square
      logic [31:0] sh, sl;

      always_comb begin
         sh = square_step(xh_ff[k]);
         sl = square_step(xl_ff[k]);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            xh_ff[k+1] <= sh[30:0];
            xl_ff[k+1] <= sl[30:0];
            fh_ff[k+1] <= {fh_ff[k][22:0], sh[31]};
            fl_ff[k+1] <= {fl_ff[k][22:0], sl[31]};
            eh_ff[k+1] <= eh_ff[k];
            el_ff[k+1] <= el_ff[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Log difference, then conversion to a natural log.
   // ------------------------------------------------------------------
   logic [29:0] lhi, llo;
   logic [29:0] lg_ff, lg_in;
   logic [61:0] lnp;
   logic [29:0] ln_ff;

   always_comb begin
      lhi   = {eh_ff[NUM_SQ], fh_ff[NUM_SQ]};
      llo   = {el_ff[NUM_SQ], fl_ff[NUM_SQ]};
      lg_in = (lhi > llo) ? lhi - llo : '0;
      lnp   = 62'(lg_ff) * 62'(LN2_Q32);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lg_ff <= lg_in;
         ln_ff <= lnp[61:32];
      end
   end

   // ------------------------------------------------------------------
   // Divider: 100*k2*2^24 over the natural log, one quotient bit a stage.
   // The dividend register fills with quotient bits as it shifts out.
   // ------------------------------------------------------------------
   logic [38:0]               k2x100;
   logic [Q_BITS:0][62:0]     dvd_ff;
   logic [Q_BITS:0][29:0]     rem_ff;
   logic [Q_BITS:0][29:0]     dsr_ff;

   assign k2x100 = 39'(k2_ff) * 39'd100;

   always_ff @(posedge clock) begin
      if (adv) begin
         dvd_ff[0] <= {k2x100, 24'b0};
         rem_ff[0] <= '0;
         dsr_ff[0] <= ln_ff;
      end
   end

   for (genvar j = 0; j < Q_BITS; j++) begin : g_divide
      logic [30:0] trial;
      logic        ge;
      logic [30:0] diff;

      always_comb begin
         trial = {rem_ff[j], dvd_ff[j][62]};
         diff  = trial - {1'b0, dsr_ff[j]};
         ge    = trial >= {1'b0, dsr_ff[j]};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j+1] <= ge ? diff[29:0] : trial[29:0];
            dvd_ff[j+1] <= {dvd_ff[j][61:0], ge};
            dsr_ff[j+1] <= dsr_ff[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output stage: convert centi-kelvin to centi-degrees, truncate
   // toward zero and saturate.
   // ------------------------------------------------------------------
   logic signed [64:0] vk, vt;
   logic signed [48:0] vq;
   pix_type            res_therm;

   always_comb begin
      vk        = $signed({2'b00, dvd_ff[Q_BITS]}) - ZERO_C_Q16;
      vt        = vk[64] ? vk + 65'sd65535 : vk;
      vq        = $signed(vt[64:16]);
      res_therm = sat16(65'(vq));
   end

   // ------------------------------------------------------------------
   // Side band: fill flag, early result and its hold flag travel along.
   // ------------------------------------------------------------------
   carry_type carry_ff [1:S_OUT];
   carry_type carry_in [1:S_OUT];

   always_comb begin
      carry_in[1].fill = (req_channel.pixel_dn == in_fill_ff) ||
                         (req_channel.qa_value == qa_fill_ff);
      carry_in[1].hold = 1'b1;
      carry_in[1].res  = '0;
      for (int k = 2; k <= S_OUT; k++) begin
         carry_in[k] = carry_ff[k-1];
      end
      carry_in[S_SEL].hold = hold_sel;
      carry_in[S_SEL].res  = res_sel;
      // A zero logarithm sends the temperature to the top of the range.
      if (!carry_ff[S_DIV0-1].hold && (ln_ff == '0)) begin
         carry_in[S_DIV0].hold = 1'b1;
         carry_in[S_DIV0].res  = POS_LIMIT;
      end
      if (carry_ff[S_OUT-1].fill) begin
         carry_in[S_OUT].res = PIXEL_FILL;
      end else if (!carry_ff[S_OUT-1].hold) begin
         carry_in[S_OUT].res = res_therm;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         carry_ff <= carry_in;
      end
   end

   assign rsp_channel.valid     = valid_ff[S_OUT];
   assign rsp_channel.pixel_out = carry_ff[S_OUT].res;
   assign rsp_channel.is_fill   = carry_ff[S_OUT].fill;

endmodule
